// ===== sv/bitmap_frame_allocator_unit_defines.svh =====
// Assertion macros for the bitmap frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/bfa_pkg.sv =====
// Types and constants shared by the bitmap frame allocator modules.
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int WORD_BITS   = 64;
  localparam int WORD_LOG    = 6;
  localparam int INDEX_W     = 20;
  localparam int FRAME_OUT_W = 16;
  localparam int COUNT_OUT_W = 17;

  localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] ONE_WORD  = {{(WORD_BITS-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESERVE = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NONE    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_REPLY
  } state_t;

  typedef struct packed {
    command_t             command;
    logic [INDEX_W-1:0]   frame_sel;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [FRAME_OUT_W-1:0] frame_out;
    logic [COUNT_OUT_W-1:0] free_count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/bfa_map_ram.sv =====
// Used-map memory: one write port, one registered read port, one map word per entry.
`timescale 1ns / 1ps
`default_nettype none
module bfa_map_ram
  import bfa_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WORD_BITS-1:0] wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bfa_first_free.sv =====
// Find-first search unit: lowest set bit of a candidate word.
`timescale 1ns / 1ps
`default_nettype none
module bfa_first_free
  import bfa_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] cand,
  output logic                      found,
  output logic [WORD_LOG-1:0]       pos
);

  always_comb begin
    found = |cand;
    pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = WORD_LOG'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/bitmap_frame_allocator_unit.sv =====
// Free, release and reserve go through S_READ, S_CHECK, S_REPLY after acceptance;
// rejected ones go straight to S_REPLY, which waits while a held reply is stalled.
// Allocate reads one 64-frame word per S_READ/S_CHECK pass from the hint word, up to
// ceil(NUM_FRAMES/64)+1 words. Throughput: one request at a time; the next is taken
// the cycle after the reply word loads. Reset: synchronous; a clearing pass marks
// every frame used, one map word per cycle; no request is taken during the pass.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_frame_allocator_unit_defines.svh"
module bitmap_frame_allocator_unit
  import bfa_pkg::*;
#(
  parameter int NUM_FRAMES = 65536
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW        = $clog2(NUM_FRAMES + 1);
  localparam int FW        = AW + WORD_LOG;
  localparam int SW        = $clog2(NUM_WORDS + 1);
  localparam logic [INDEX_W:0] FRAMES_X  = (INDEX_W + 1)'(NUM_FRAMES);
  localparam logic [AW-1:0]    LAST_WORD = AW'(NUM_WORDS - 1);

  state_t                state, state_next;
  command_t              cmd, cmd_next;
  logic [INDEX_W-1:0]    idx, idx_next;
  logic [AW-1:0]         waddr, waddr_next;
  logic [SW-1:0]         step, step_next;
  logic                  first, first_next;
  logic [WORD_LOG-1:0]   boff, boff_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         hint, hint_next;
  status_t               st, st_next;
  logic [FRAME_OUT_W-1:0] fo, fo_next;
  logic                  rsp_valid_next;
  logic                  rsp_load;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata, rdata;

  logic [WORD_BITS-1:0]  mask, cand, bit_sel;
  logic                  found, used_bit, out_free;
  logic [WORD_LOG-1:0]   pos, bsel;
  logic [FW-1:0]         fnum;
  logic [CW-1:0]         start;

  bfa_map_ram #(
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (waddr),
    .rdata (rdata)
  );

  bfa_first_free u_find (
    .cand  (cand),
    .found (found),
    .pos   (pos)
  );

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // first word of a scan skips the frames below the hint
  assign mask     = first ? (FULL_WORD << boff) : FULL_WORD;
  assign cand     = ~rdata & mask;
  assign fnum     = {waddr, pos};
  assign bsel     = idx[WORD_LOG-1:0];
  assign bit_sel  = ONE_WORD << bsel;
  assign used_bit = rdata[bsel];
  assign start    = (hint == CW'(NUM_FRAMES)) ? '0 : hint;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      waddr     <= '0;
      count     <= '0;
      hint      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      waddr     <= waddr_next;
      count     <= count_next;
      hint      <= hint_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    idx   <= idx_next;
    step  <= step_next;
    first <= first_next;
    boff  <= boff_next;
    st    <= st_next;
    fo    <= fo_next;
    if (rsp_load) begin
      rsp.status     <= st;
      rsp.frame_out  <= fo;
      rsp.free_count <= COUNT_OUT_W'(count);
    end
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    idx_next       = idx;
    waddr_next     = waddr;
    step_next      = step;
    first_next     = first;
    boff_next      = boff;
    count_next     = count;
    hint_next      = hint;
    st_next        = st;
    fo_next        = fo;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_load       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = waddr;
    ram_wdata      = FULL_WORD;

    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (waddr == LAST_WORD) begin
          waddr_next = '0;
          state_next = S_IDLE;
        end else begin
          waddr_next = waddr + 1'b1;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          cmd_next = req.command;
          idx_next = req.frame_sel;
          fo_next  = '0;
          st_next  = ST_DONE;
          if (req.command == CMD_ALLOC) begin
            if (count == '0) begin
              st_next    = ST_NONE;
              state_next = S_REPLY;
            end else begin
              waddr_next = AW'(start >> WORD_LOG);
              boff_next  = start[WORD_LOG-1:0];
              first_next = 1'b1;
              step_next  = '0;
              state_next = S_READ;
            end
          end else if ({1'b0, req.frame_sel} >= FRAMES_X) begin
            st_next    = ST_IGNORED;
            state_next = S_REPLY;
          end else begin
            waddr_next = AW'(req.frame_sel >> WORD_LOG);
            state_next = S_READ;
          end
        end
      end

      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_CHECK;
      end

      S_CHECK: begin
        st_next    = ST_DONE;
        state_next = S_REPLY;
        case (cmd)
          CMD_ALLOC: begin
            if (found) begin
              ram_we     = 1'b1;
              ram_wdata  = rdata | (ONE_WORD << pos);
              count_next = count - CW'(1);
              hint_next  = CW'(fnum) + CW'(1);
              fo_next    = FRAME_OUT_W'(fnum);
            end else if (step == SW'(NUM_WORDS)) begin
              st_next = ST_NONE;
            end else begin
              // advance to the next word, wrapping to word zero
              waddr_next = (waddr == LAST_WORD) ? '0 : waddr + 1'b1;
              first_next = 1'b0;
              step_next  = step + 1'b1;
              state_next = S_READ;
            end
          end
          CMD_FREE: begin
            if (used_bit) begin
              ram_we     = 1'b1;
              ram_wdata  = rdata & ~bit_sel;
              count_next = count + CW'(1);
              if ({1'b0, idx} < (INDEX_W + 1)'(hint)) begin
                hint_next = CW'(idx);
              end
            end else begin
              st_next = ST_IGNORED;
            end
          end
          CMD_RELEASE: begin
            if (used_bit) begin
              ram_we     = 1'b1;
              ram_wdata  = rdata & ~bit_sel;
              count_next = count + CW'(1);
            end
          end
          CMD_RESERVE: begin
            if (!used_bit) begin
              ram_we     = 1'b1;
              ram_wdata  = rdata | bit_sel;
              count_next = count - CW'(1);
            end
          end
          default: begin
            st_next = ST_IGNORED;
          end
        endcase
      end

      S_REPLY: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_load       = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BFA_ASSERT_ALWAYS(a_reset_clears, rst |=> state == S_CLEAR, "reset must start clearing pass")
  `BFA_ASSERT(a_quiet_clear, state == S_CLEAR |-> !rsp_valid, "response during clearing pass")
  `BFA_ASSERT(a_accept_busy, req_valid && !req_stall |=> state != S_IDLE, "accepted word idle")
  `BFA_ASSERT(a_count_bound, count <= CW'(NUM_FRAMES), "free count exceeds frame total")
  `BFA_ASSERT(a_scan_bound, state == S_CHECK |-> step <= SW'(NUM_WORDS), "scan ran past the map")
  `BFA_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(state) == S_REPLY, "response not from reply")

endmodule
`default_nettype wire

// ===== tb/frame_alloc_checker.sv =====
// Reply checker for the bitmap frame allocator: models the used map and compares every reply.
`timescale 1ns / 1ps
module frame_alloc_checker
  import bfa_pkg::*;
#(
  parameter int FRAMES = 65536
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_stall,
  input  wire req_t req,
  input  wire logic rsp_valid,
  input  wire logic rsp_stall,
  input  wire rsp_t rsp,
  output int        fail_count,
  output int        pending
);

  localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;

  logic [WORD_BITS-1:0] used_words [MAP_WORDS];
  int unsigned          next_hint;
  int unsigned          open_frames;
  int                   fails;
  rsp_t                 replies_due [$];
  rsp_t                 want;

  function automatic bit frame_used(input int unsigned f);
    return used_words[f / WORD_BITS][f % WORD_BITS];
  endfunction

  function automatic void mark_frame(input int unsigned f, input bit used);
    used_words[f / WORD_BITS][f % WORD_BITS] = used;
  endfunction

  // First free frame in [lo, hi); skip whole words that are fully used.
  function automatic bit first_open_frame(input int unsigned lo, input int unsigned hi,
                                          output int unsigned found_at);
    int unsigned f;
    f = lo;
    found_at = 0;
    while (f < hi) begin
      if (f % WORD_BITS == 0 && f + WORD_BITS <= hi && used_words[f / WORD_BITS] == FULL_WORD) begin
        f += WORD_BITS;
      end else if (!frame_used(f)) begin
        found_at = f;
        return 1'b1;
      end else begin
        f++;
      end
    end
    return 1'b0;
  endfunction

  // Apply one command to the map model and return the reply word it must produce.
  function automatic rsp_t apply_command(input req_t w);
    rsp_t        r;
    int unsigned idx;
    int unsigned f;
    bit          found;
    r.status    = ST_DONE;
    r.frame_out = '0;
    idx         = 32'(w.frame_sel);
    f           = 0;
    found       = 1'b0;
    if (w.command == CMD_ALLOC) begin
      if (open_frames != 0) begin
        found = first_open_frame(next_hint, FRAMES, f);
        if (!found) found = first_open_frame(0, next_hint, f);
      end
      if (found) begin
        mark_frame(f, 1'b1);
        open_frames--;
        next_hint   = f + 1;
        r.frame_out = f[FRAME_OUT_W-1:0];
      end else begin
        r.status = ST_NONE;
      end
    end else if (idx >= FRAMES) begin
      r.status = ST_IGNORED;
    end else begin
      case (w.command)
        CMD_FREE: begin
          if (frame_used(idx)) begin
            mark_frame(idx, 1'b0);
            open_frames++;
            if (idx < next_hint) next_hint = idx;
          end else begin
            r.status = ST_IGNORED;
          end
        end
        CMD_RELEASE: begin
          if (frame_used(idx)) begin
            mark_frame(idx, 1'b0);
            open_frames++;
          end
        end
        default: begin
          if (!frame_used(idx)) begin
            mark_frame(idx, 1'b1);
            open_frames--;
          end
        end
      endcase
    end
    r.free_count = open_frames[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic void report(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    fails++;
    $display("%0t: %s mismatch, expected %0d got %0d", $time, field, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_WORDS; i++) used_words[i] = FULL_WORD;
      next_hint   = 0;
      open_frames = 0;
      replies_due.delete();
    end else begin
      if (req_valid && !req_stall) replies_due.push_back(apply_command(req));
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, got status %0d frame %0d count %0d",
                   $time, rsp.status, rsp.frame_out, rsp.free_count);
        end else begin
          want = replies_due.pop_front();
          if (rsp.status !== want.status)
            report("status", 32'(want.status), 32'(rsp.status));
          if (rsp.frame_out !== want.frame_out)
            report("frame_out", 32'(want.frame_out), 32'(rsp.frame_out));
          if (rsp.free_count !== want.free_count)
            report("free_count", 32'(want.free_count), 32'(rsp.free_count));
        end
      end
    end
    // publish after the edge so readers see settled values
    fail_count <= fails;
    pending    <= replies_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the frame allocator testbench: clock, reset, request stimulus, reply stalls, verdict.
`timescale 1ns / 1ps
module tb;
  import bfa_pkg::*;

  localparam int FRAMES       = 65536;
  localparam int RANDOM_WORDS = 1425;
  localparam int CALM_WORDS   = 120;
  localparam int PHASE_WORDS  = 150;
  localparam int SCAN_CYCLES  = 2 * (FRAMES / WORD_BITS + 1) + 8;
  // worst case: every word a full wrapped scan plus both sides idling, taken several times
  localparam int LIMIT_CYCLES = 14_000_000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  int   cycle_count;
  bit   sender_gaps;
  bit   receiver_stalls;
  bit   calm;

  bitmap_frame_allocator_unit #(.NUM_FRAMES(FRAMES)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  frame_alloc_checker #(.FRAMES(FRAMES)) reply_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // Receiver side: random stall bursts when stalls are enabled and the phase is not calm.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && receiver_stalls && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic req_t make_word(input command_t c, input int unsigned idx);
    req_t w;
    w.command   = c;
    w.frame_sel = INDEX_W'(idx);
    return w;
  endfunction

  // Keep most indexes in a small low window so next-fit scans stay short.
  function automatic req_t random_word();
    int               pick;
    command_t         c;
    int unsigned      idx;
    pick = $urandom_range(0, 99);
    if (pick < 35)      c = CMD_ALLOC;
    else if (pick < 60) c = CMD_FREE;
    else if (pick < 80) c = CMD_RELEASE;
    else                c = CMD_RESERVE;
    pick = $urandom_range(0, 99);
    if (pick < 75)      idx = $urandom_range(0, 383);
    else if (pick < 82) idx = $urandom_range(FRAMES - 128, FRAMES - 1);
    else if (pick < 88) idx = $urandom_range(FRAMES, (1 << INDEX_W) - 1);
    else                idx = $urandom_range(0, FRAMES - 1);
    return make_word(c, idx);
  endfunction

  task automatic send_word(input req_t w);
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_replies();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    req_t w;
    int   sent;
    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    calm            = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pool, double free, range edges, wrap, hint at the end, hint pulled back
    send_word(make_word(CMD_ALLOC, '1));
    send_word(make_word(CMD_FREE, 0));
    send_word(make_word(CMD_FREE, 0));
    send_word(make_word(CMD_ALLOC, 0));
    send_word(make_word(CMD_RELEASE, FRAMES - 1));
    send_word(make_word(CMD_RELEASE, FRAMES - 1));
    send_word(make_word(CMD_RESERVE, FRAMES - 1));
    send_word(make_word(CMD_RESERVE, FRAMES - 1));
    send_word(make_word(CMD_FREE, FRAMES));
    send_word(make_word(CMD_RELEASE, '1));
    send_word(make_word(CMD_RESERVE, '1));
    send_word(make_word(CMD_RELEASE, 100));
    send_word(make_word(CMD_ALLOC, 0));
    send_word(make_word(CMD_RELEASE, 5));
    send_word(make_word(CMD_ALLOC, 0));
    send_word(make_word(CMD_FREE, FRAMES - 1));
    send_word(make_word(CMD_ALLOC, 0));
    send_word(make_word(CMD_ALLOC, 0));
    send_word(make_word(CMD_RELEASE, 3));
    send_word(make_word(CMD_ALLOC, 0));
    send_word(make_word(CMD_RELEASE, 10));
    send_word(make_word(CMD_RELEASE, 20));
    send_word(make_word(CMD_ALLOC, 0));
    send_word(make_word(CMD_FREE, 7));
    send_word(make_word(CMD_ALLOC, 0));
    drain_replies();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent % PHASE_WORDS == PHASE_WORDS - 1) begin
        drain_replies();
        sender_gaps     = 1'($urandom_range(0, 1));
        receiver_stalls = 1'($urandom_range(0, 1));
      end
      if (sent >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if (sender_gaps && !calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
      w = random_word();
      send_word(w);
      sent++;
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
